FILE: rtl/core/vcp_clp_pkg.sv
// Shared types, character codes and helpers for the VCP capability list parser.
// No dependencies; imported by every module of the block.
package vcp_clp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_CONT   = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // End status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SECTION = 2'd1;
  localparam logic [1:0] ST_UNBALANCED = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_V     = 8'h76;

  // Digit counter saturates one past the longest token that keeps its value
  localparam int unsigned TOKEN_MAX_DIGITS = 16;
  localparam logic [4:0] DIGIT_SAT = 5'(TOKEN_MAX_DIGITS + 1);
  localparam logic [4:0] DIGIT_LIM = 5'(TOKEN_MAX_DIGITS);

  typedef enum logic [5:0] {
    PH_SEARCH = 6'b000001,
    PH_TOP    = 6'b000010,
    PH_AFTER  = 6'b000100,
    PH_LIST   = 6'b001000,
    PH_DONE   = 6'b010000,
    PH_FAIL   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code;
    logic [7:0] value;
    logic       last_value;
    logic [1:0] status;
  } res_t;

  // Up to two results from one character
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Characters of the lowercase "vcp(" section key
  function automatic logic [7:0] section_key(input logic [1:0] idx);
    logic [7:0] k;
    case (idx)
      2'd0:    k = 8'h76;
      2'd1:    k = 8'h63;
      2'd2:    k = 8'h70;
      default: k = 8'h28;
    endcase
    return k;
  endfunction

  // Returns {is_hex, digit}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0b ||
           c == 8'h0c || c == 8'h0d;
  endfunction

  function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] code,
                                  input logic [7:0] value, input logic last_value,
                                  input logic [1:0] status);
    res_t r;
    r.kind       = kind;
    r.code       = code;
    r.value      = value;
    r.last_value = last_value;
    r.status     = status;
    return r;
  endfunction

endpackage

FILE: rtl/core/vcp_clp_parse.sv
// Parser state and per-character update: section search, depth, hex tokens, lists.
// Depends on vcp_clp_pkg.
module vcp_clp_parse
  import vcp_clp_pkg::*;
#(
  parameter int unsigned MAX_NEST_DEPTH = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,      // process the registered character this cycle
  input  logic [7:0] ch,
  input  logic       eos,
  output push_t      push
);

  localparam int unsigned DW = $clog2(MAX_NEST_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_NEST_DEPTH);

  phase_t        ph_r, ph_nxt;
  logic [1:0]    mi_r, mi_nxt;
  logic [DW-1:0] dep_r, dep_nxt;
  logic [7:0]    acc_r, acc_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [7:0]    pc_r, pc_nxt;
  logic [7:0]    pv_r, pv_nxt;
  logic          pvv_r, pvv_nxt;

  logic [4:0]    hd;
  logic [7:0]    tok;
  logic [7:0]    lc;

  assign hd  = hex_decode(ch);
  assign tok = (cnt_r > DIGIT_LIM) ? 8'hff : acc_r;
  assign lc  = (ch >= 8'h41 && ch <= 8'h5a) ? ch + 8'd32 : ch;

  // Next state and results for one character
  always_comb begin
    logic [1:0] n;
    res_t       r0, r1, it;
    logic       emit;
    logic [DW-1:0] dv;

    ph_nxt  = ph_r;
    mi_nxt  = mi_r;
    dep_nxt = dep_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    pc_nxt  = pc_r;
    pv_nxt  = pv_r;
    pvv_nxt = pvv_r;
    n  = 2'd0;
    r0 = '0;
    r1 = '0;
    it = '0;
    emit = 1'b0;
    dv = dep_r;

    unique case (ph_r)
      PH_SEARCH: begin
        if (lc == section_key(mi_r)) begin
          if (mi_r == 2'd3) begin
            mi_nxt  = 2'd0;
            ph_nxt  = PH_TOP;
            dep_nxt = DW'(1);
          end else begin
            mi_nxt = mi_r + 2'd1;
          end
        end else begin
          mi_nxt = (lc == CH_V) ? 2'd1 : 2'd0;
        end
      end

      PH_TOP, PH_AFTER: begin
        if (hd[4]) begin
          if (ph_r == PH_AFTER) begin
            r0 = mk_res(KIND_CONT, pc_r, 8'd0, 1'b0, ST_OK);
            n  = 2'd1;
            ph_nxt = PH_TOP;
          end
          acc_nxt = {acc_r[3:0], hd[3:0]};
          cnt_nxt = (cnt_r < DIGIT_SAT) ? cnt_r + 5'd1 : cnt_r;
        end else begin
          // close a pending code token
          if (ph_r == PH_TOP && cnt_r != 5'd0) begin
            pc_nxt  = tok;
            acc_nxt = 8'd0;
            cnt_nxt = 5'd0;
            ph_nxt  = PH_AFTER;
          end
          if (ch == CH_OPEN) begin
            if (dep_r >= DEPTH_MAX) begin
              ph_nxt = PH_FAIL;
            end else begin
              dep_nxt = dep_r + DW'(1);
              if (ph_nxt == PH_AFTER) begin
                ph_nxt  = PH_LIST;
                pvv_nxt = 1'b0;
                acc_nxt = 8'd0;
                cnt_nxt = 5'd0;
              end
            end
          end else if (!is_space(ch)) begin
            if (ph_nxt == PH_AFTER) begin
              r0 = mk_res(KIND_CONT, pc_nxt, 8'd0, 1'b0, ST_OK);
              n  = 2'd1;
              ph_nxt = PH_TOP;
            end
            if (ch == CH_CLOSE) begin
              dv = (dep_r != '0) ? dep_r - DW'(1) : dep_r;
              dep_nxt = dv;
              if (dv == '0) ph_nxt = PH_DONE;
            end
          end
        end
      end

      PH_LIST: begin
        if (hd[4]) begin
          acc_nxt = {acc_r[3:0], hd[3:0]};
          cnt_nxt = (cnt_r < DIGIT_SAT) ? cnt_r + 5'd1 : cnt_r;
        end else begin
          // a finished value token releases the previous value
          if (cnt_r != 5'd0) begin
            if (pvv_r) begin
              r0 = mk_res(KIND_VALUE, pc_r, pv_r, 1'b0, ST_OK);
              n  = 2'd1;
            end
            pv_nxt  = tok;
            pvv_nxt = 1'b1;
            acc_nxt = 8'd0;
            cnt_nxt = 5'd0;
          end
          if (ch == CH_OPEN) begin
            if (dep_r >= DEPTH_MAX) ph_nxt = PH_FAIL;
            else dep_nxt = dep_r + DW'(1);
          end else if (ch == CH_CLOSE) begin
            if (dep_r != '0) dep_nxt = dep_r - DW'(1);
            if (pvv_nxt) it = mk_res(KIND_VALUE, pc_r, pv_nxt, 1'b1, ST_OK);
            else it = mk_res(KIND_CONT, pc_r, 8'd0, 1'b0, ST_OK);
            if (n == 2'd0) r0 = it;
            else r1 = it;
            n = n + 2'd1;
            pvv_nxt = 1'b0;
            ph_nxt  = PH_TOP;
          end
        end
      end

      PH_DONE, PH_FAIL: begin
        // rest of the string is ignored
      end

      default: begin
        ph_nxt = PH_SEARCH;
      end
    endcase

    // Final character: status, then back to reset state
    if (eos) begin
      emit = (ph_nxt == PH_DONE);
      if (emit) begin
        it = mk_res(KIND_STATUS, 8'd0, 8'd0, 1'b0, ST_OK);
      end else begin
        n  = 2'd0;
        it = mk_res(KIND_STATUS, 8'd0, 8'd0, 1'b0,
                    (ph_nxt == PH_SEARCH) ? ST_NO_SECTION : ST_UNBALANCED);
      end
      if (n == 2'd0) begin
        r0 = it;
        n  = 2'd1;
      end else if (n == 2'd1) begin
        r1 = it;
        n  = 2'd2;
      end
      ph_nxt  = PH_SEARCH;
      mi_nxt  = 2'd0;
      dep_nxt = '0;
      acc_nxt = 8'd0;
      cnt_nxt = 5'd0;
      pc_nxt  = 8'd0;
      pv_nxt  = 8'd0;
      pvv_nxt = 1'b0;
    end

    push.cnt = fire ? n : 2'd0;
    push.r0  = r0;
    push.r1  = r1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_SEARCH;
      mi_r  <= 2'd0;
      dep_r <= '0;
      acc_r <= 8'd0;
      cnt_r <= 5'd0;
      pc_r  <= 8'd0;
      pv_r  <= 8'd0;
      pvv_r <= 1'b0;
    end else if (fire) begin
      ph_r  <= ph_nxt;
      mi_r  <= mi_nxt;
      dep_r <= dep_nxt;
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      pc_r  <= pc_nxt;
      pv_r  <= pv_nxt;
      pvv_r <= pvv_nxt;
    end
  end

endmodule

FILE: rtl/core/vcp_clp_outq.sv
// Four-entry result queue: takes up to two results a cycle, hands out one while out_ready is high.
// Depends on vcp_clp_pkg.
module vcp_clp_outq
  import vcp_clp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,       // at least two free entries after this cycle's pop
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  res_t       q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [2:0] after_pop;

  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && out_ready;
  assign after_pop = cnt_r - {2'b00, pop};
  assign room      = (after_pop <= 3'd2);
  assign out_res   = q_r[rp_r];
  assign cnt_nxt   = after_pop + {1'b0, push.cnt};

  // Entry writes
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) q_r[wp_r] <= push.r0;
    if (push.cnt == 2'd2) q_r[wp_r + 2'd1] <= push.r1;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_r + push.cnt;
      rp_r  <= rp_r + {1'b0, pop};
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/vcp_capability_list_parser.sv
// VCP capability list parser. Give it a capabilities string one byte per request
// with tlast on the final byte. It finds the first "vcp(" (any case), then emits a
// continuous-code item or one item per listed value for every feature code in that
// section, and a status item on the final byte (ok, no section, or unbalanced; when
// not ok, only the status comes out). One byte is taken per cycle when the consumer
// keeps up: the byte sits in an input register, the parser updates its state from
// it, and results go to a four-entry queue that hands out one result per cycle
// while out_tready is high, so bytes that yield two results can hold up the input.
// Depends on vcp_clp_pkg, vcp_clp_parse and vcp_clp_outq.
module vcp_capability_list_parser
  import vcp_clp_pkg::*;
#(
  parameter int unsigned MAX_NEST_DEPTH = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // end_of_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] code, [15:8] value, [17:16] status, rest 0
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last_value
);

  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_eos_r;
  logic       room, fire;
  push_t      push;
  res_t       res;

  assign fire      = s1_valid_r && room;
  assign in_tready = !s1_valid_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_ch_r  <= in_tdata;
      s1_eos_r <= in_tlast;
    end
  end

  vcp_clp_parse #(
    .MAX_NEST_DEPTH(MAX_NEST_DEPTH)
  ) u_parse (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .ch   (s1_ch_r),
    .eos  (s1_eos_r),
    .push (push)
  );

  vcp_clp_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  assign out_tdata = {6'd0, res.status, res.value, res.code};
  assign out_tuser = res.kind;
  assign out_tlast = res.last_value;

endmodule
